### design/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform
// Element and word types, pipeline sizing and the lane control bundle.
// ----------------------------------------------------------------------------
package mvt_pkg;

  // Fixed-point element width and default fraction bits.
  localparam int ELEM_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Matrix dimension, element count and index width.
  localparam int DIM      = 4;
  localparam int NUM_ELEM = DIM * DIM;
  localparam int IDX_W    = $clog2(NUM_ELEM);

  // Full-width product and the accumulator that holds the sum of DIM products.
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(DIM);

  // Operation codes of a command word.
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  typedef logic signed [ELEM_WIDTH-1:0] mvt_elem_t;
  typedef logic signed [PROD_W-1:0]     mvt_prod_t;
  typedef logic signed [ACC_W-1:0]      mvt_acc_t;

  // Command word.
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] elem_index;
    mvt_elem_t        elem_value;
    mvt_elem_t        vec_x;
    mvt_elem_t        vec_y;
    mvt_elem_t        vec_z;
    mvt_elem_t        vec_w;
  } mvt_cmd_t;

  // Response word.
  typedef struct packed {
    mvt_elem_t res_x;
    mvt_elem_t res_y;
    mvt_elem_t res_z;
    mvt_elem_t res_w;
    logic      saturated;
  } mvt_rsp_t;

  // Per-stage load enables handed to every lane.
  typedef struct packed {
    logic prod_en;
    logic sum_en;
    logic sat_en;
  } mvt_adv_t;

  // One lane's finished component.
  typedef struct packed {
    mvt_elem_t value;
    logic      sat;
  } mvt_lane_res_t;

endpackage

### design/mvt_lane.sv
// ----------------------------------------------------------------------------
// mvt_lane: one row of the matrix-vector product
// Multiplies a matrix row by the vector, sums the products at full width,
// shifts out the fraction bits and saturates to the element range.
// ----------------------------------------------------------------------------
module mvt_lane
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  mvt_adv_t             adv,
  input  mvt_elem_t [DIM-1:0]  row,
  input  mvt_elem_t [DIM-1:0]  vec,
  output mvt_lane_res_t        result
);

  mvt_prod_t [DIM-1:0] prod;
  mvt_prod_t [DIM-1:0] prod_next;
  mvt_acc_t            acc;
  mvt_acc_t            acc_next;
  mvt_acc_t            shifted;
  mvt_lane_res_t       result_next;

  // Stage one: one signed multiplier per column.
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      prod_next[c] = row[c] * vec[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.prod_en) begin
      prod <= prod_next;
    end
  end

  // Stage two: exact sum of the row's products.
  always_comb begin
    acc_next = '0;
    for (int c = 0; c < DIM; c++) begin
      acc_next = acc_next + ACC_W'(prod[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sum_en) begin
      acc <= acc_next;
    end
  end

  // Stage three: arithmetic shift, then clamp when the upper bits are not
  // all copies of the sign.
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    if ((&shifted[ACC_W-1:ELEM_WIDTH-1]) || !(|shifted[ACC_W-1:ELEM_WIDTH-1])) begin
      result_next.value = shifted[ELEM_WIDTH-1:0];
      result_next.sat   = 1'b0;
    end else if (shifted[ACC_W-1]) begin
      result_next.value = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
      result_next.sat   = 1'b1;
    end else begin
      result_next.value = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      result_next.sat   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sat_en) begin
      result <= result_next;
    end
  end

endmodule

### design/mvt_merge.sv
// ----------------------------------------------------------------------------
// mvt_merge: output stage
// Gathers the four lane components into one response word, combines the
// saturation flags and holds the word until the receiver takes it.
// ----------------------------------------------------------------------------
module mvt_merge
  import mvt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     lanes_valid,
  input  mvt_lane_res_t [DIM-1:0]  lanes,
  output logic                     take,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output mvt_rsp_t                 rsp_word
);

  mvt_rsp_t rsp_word_next;

  // The output register loads whenever it is empty or its word is taken.
  assign take = !rsp_valid || !rsp_stall;

  // Combine the lanes into one word.
  always_comb begin
    rsp_word_next.res_x     = lanes[0].value;
    rsp_word_next.res_y     = lanes[1].value;
    rsp_word_next.res_z     = lanes[2].value;
    rsp_word_next.res_w     = lanes[3].value;
    rsp_word_next.saturated = lanes[0].sat | lanes[1].sat | lanes[2].sat | lanes[3].sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= lanes_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_word <= rsp_word_next;
    end
  end

endmodule

### design/matrix_vector_transform_4x4.sv
// A response word passes the lane product, sum and saturation registers, then the
// merge's response register. Throughput: one command per cycle when not stalled,
// set by the four row lanes, each with its own four multipliers, and a four-stage
// pipeline whose stages advance apart. Reset clears the stage valid bits only; the
// matrix store holds no defined value until each element is written.
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4: 4x4 matrix times 4-component vector
// Holds a row-major Q format matrix, written one element per word, and
// transforms vectors through four parallel row lanes and an output merge.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  mvt_cmd_t cmd_word,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output mvt_rsp_t rsp_word
);

  mvt_elem_t [NUM_ELEM-1:0] mat;
  mvt_elem_t [DIM-1:0]      vec;
  mvt_lane_res_t [DIM-1:0]  lane_res;
  mvt_adv_t                 adv;
  logic                     accept;
  logic                     take;
  logic                     prod_valid;
  logic                     sum_valid;
  logic                     sat_valid;

  // Each stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv.sat_en  = !sat_valid || take;
    adv.sum_en  = !sum_valid || adv.sat_en;
    adv.prod_en = !prod_valid || adv.sum_en;
  end

  assign cmd_stall = !adv.prod_en;
  assign accept    = cmd_valid && adv.prod_en;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
      sat_valid  <= 1'b0;
    end else begin
      if (adv.prod_en) begin
        prod_valid <= accept && (cmd_word.op == OP_TRANSFORM);
      end
      if (adv.sum_en) begin
        sum_valid <= prod_valid;
      end
      if (adv.sat_en) begin
        sat_valid <= sum_valid;
      end
    end
  end

  // Matrix store: one element written per accepted write word.
  always_ff @(posedge clk) begin
    if (accept && (cmd_word.op == OP_WRITE)) begin
      mat[cmd_word.elem_index] <= cmd_word.elem_value;
    end
  end

  assign vec = {cmd_word.vec_w, cmd_word.vec_z, cmd_word.vec_y, cmd_word.vec_x};

  // One lane per matrix row.
  for (genvar r = 0; r < DIM; r++) begin : g_lane
    mvt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .adv   (adv),
      .row   (mat[r*DIM +: DIM]),
      .vec   (vec),
      .result(lane_res[r])
    );
  end

  // Output merge and response register.
  mvt_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lanes_valid(sat_valid),
    .lanes      (lane_res),
    .take       (take),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_word   (rsp_word)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for matrix_vector_transform_4x4
// Streams element writes and vector transforms through the block with bursty
// command traffic and a stalling response side. A shadow copy of the matrix
// predicts every response word in Q16.16 with saturation. Each response is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mvt_pkg::*;

  localparam int LATENCY    = 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM   = 1680;
  localparam int PAUSE_AT   = 900;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 200;

  localparam mvt_elem_t Q_MAX = 32'sh7FFF_FFFF;
  localparam mvt_elem_t Q_MIN = 32'sh8000_0000;
  localparam mvt_elem_t Q_ONE = 32'sh0001_0000;
  localparam mvt_elem_t Q_EPS = 32'sh0000_0001;
  localparam logic signed [71:0] SUM_MAX = 72'sh7FFF_FFFF;
  localparam logic signed [71:0] SUM_MIN = -72'sh8000_0000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  mvt_cmd_t cmd_word = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  mvt_rsp_t rsp_word;

  // Shadow matrix, words waiting to be offered, and predicted responses.
  mvt_elem_t mat_shadow [NUM_ELEM];
  mvt_cmd_t  cmd_pend_q [$];
  mvt_rsp_t  rsp_expect_q [$];

  int n_fail = 0;

  matrix_vector_transform_4x4 uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the response to a transform from the shadow matrix.
  function automatic mvt_rsp_t transform_vec(mvt_cmd_t c);
    mvt_rsp_t           r;
    mvt_elem_t          vec [DIM];
    mvt_elem_t          comp [DIM];
    logic signed [71:0] acc;
    logic signed [71:0] a;
    logic signed [71:0] b;
    logic               sat;
    vec[0] = c.vec_x;
    vec[1] = c.vec_y;
    vec[2] = c.vec_z;
    vec[3] = c.vec_w;
    sat = 1'b0;
    for (int row = 0; row < DIM; row++) begin
      acc = '0;
      for (int col = 0; col < DIM; col++) begin
        a = mat_shadow[row * DIM + col];
        b = vec[col];
        acc = acc + a * b;
      end
      // Truncating shift, then clamp to the element range.
      acc = acc >>> FRAC_BITS_DEF;
      if (acc > SUM_MAX) begin
        comp[row] = Q_MAX;
        sat = 1'b1;
      end else if (acc < SUM_MIN) begin
        comp[row] = Q_MIN;
        sat = 1'b1;
      end else begin
        comp[row] = acc[ELEM_WIDTH-1:0];
      end
    end
    r.res_x     = comp[0];
    r.res_y     = comp[1];
    r.res_z     = comp[2];
    r.res_w     = comp[3];
    r.saturated = sat;
    return r;
  endfunction

  // Mostly small magnitudes so sums stay in range, with full-scale and edge values mixed in.
  function automatic mvt_elem_t rand_q16();
    mvt_elem_t v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom();
      2: begin
        case ($urandom_range(0, 5))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = -Q_EPS;
          4: v = Q_ONE;
          default: v = -Q_ONE;
        endcase
      end
      default: v = $urandom_range(0, 32'h000F_FFFF) - 32'sh0008_0000;
    endcase
    return v;
  endfunction

  // Queue an element write; the vector fields carry noise.
  task automatic queue_write(int idx, mvt_elem_t val);
    mvt_cmd_t c;
    c.op         = OP_WRITE;
    c.elem_index = IDX_W'(idx);
    c.elem_value = val;
    c.vec_x      = $urandom();
    c.vec_y      = $urandom();
    c.vec_z      = $urandom();
    c.vec_w      = $urandom();
    cmd_pend_q.push_back(c);
  endtask

  // Queue a transform; the element fields carry noise.
  task automatic queue_vec(mvt_elem_t x, mvt_elem_t y, mvt_elem_t z, mvt_elem_t w);
    mvt_cmd_t c;
    c.op         = OP_TRANSFORM;
    c.elem_index = IDX_W'($urandom_range(0, NUM_ELEM - 1));
    c.elem_value = $urandom();
    c.vec_x      = x;
    c.vec_y      = y;
    c.vec_z      = z;
    c.vec_w      = w;
    cmd_pend_q.push_back(c);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    // Row 0 overflows high, row 1 overflows low, row 2 passes z through,
    // row 3 exercises truncation toward minus infinity.
    for (int col = 0; col < DIM; col++) queue_write(col, Q_MAX);
    for (int col = 0; col < DIM; col++) queue_write(DIM + col, Q_MIN);
    for (int col = 0; col < DIM; col++) queue_write(2 * DIM + col, (col == 2) ? Q_ONE : '0);
    queue_write(3 * DIM + 0, Q_EPS);
    queue_write(3 * DIM + 1, '0);
    queue_write(3 * DIM + 2, '0);
    queue_write(3 * DIM + 3, -Q_EPS);
    queue_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    queue_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    queue_vec('0, '0, '0, '0);
    queue_vec(-Q_EPS, '0, '0, 32'sh0000_0005);
    queue_vec(Q_MAX, Q_MIN, Q_ONE, -Q_ONE);
    queue_vec(rand_q16(), rand_q16(), rand_q16(), rand_q16());

    // Random mix: mostly transforms, with element rewrites interleaved.
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_write($urandom_range(0, NUM_ELEM - 1), rand_q16());
      else
        queue_vec(rand_q16(), rand_q16(), rand_q16(), rand_q16());
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain, then give the pipeline time to show any stray word.
    do @(negedge clk);
    while (cmd_pend_q.size() != 0 || cmd_valid || rsp_expect_q.size() != 0);
    repeat (LATENCY + 4) @(negedge clk);
    if (n_fail == 0 && rsp_expect_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Command driver: bursts with gaps, one pause until all responses are back.
  int n_offered  = 0;
  int burst_left = 0;
  int gap_left   = 0;
  bit pause_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      // Update the shadow state for the word accepted at this edge.
      if (cmd_valid && !cmd_stall) begin
        if (cmd_word.op == OP_WRITE)
          mat_shadow[cmd_word.elem_index] = cmd_word.elem_value;
        else
          rsp_expect_q.push_back(transform_vec(cmd_word));
      end
      // A stalled word is held unchanged.
      if (!(cmd_valid && cmd_stall)) begin
        if (n_offered == PAUSE_AT && !pause_done && rsp_expect_q.size() != 0) begin
          cmd_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_pend_q.size() == 0) begin
          cmd_valid <= 1'b0;
        end else begin
          if (n_offered == PAUSE_AT)
            pause_done = 1'b1;
          cmd_word  <= cmd_pend_q.pop_front();
          cmd_valid <= 1'b1;
          n_offered++;
          if (burst_left > 0)
            burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 7))
              0: begin
                burst_left = $urandom_range(100, 300);
                gap_left   = 0;
              end
              1, 2: begin
                burst_left = $urandom_range(1, 4);
                gap_left   = $urandom_range(5, 20);
              end
              default: begin
                burst_left = $urandom_range(1, 16);
                gap_left   = $urandom_range(0, 3);
              end
            endcase
          end
        end
      end
    end
  end

  // Response monitor and stall pattern, with one long hold-off.
  int n_results  = 0;
  int stall_cyc  = 0;
  int stall_mode = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk) begin
    mvt_rsp_t exp_rsp;
    logic     stall_next;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_expect_q.size() == 0) begin
          $error("response word %h arrived with nothing expected", rsp_word);
          n_fail++;
        end else begin
          exp_rsp = rsp_expect_q.pop_front();
          check_field("res_x", exp_rsp.res_x, rsp_word.res_x);
          check_field("res_y", exp_rsp.res_y, rsp_word.res_y);
          check_field("res_z", exp_rsp.res_z, rsp_word.res_z);
          check_field("res_w", exp_rsp.res_w, rsp_word.res_w);
          check_field("saturated", 32'(exp_rsp.saturated), 32'(rsp_word.saturated));
        end
        n_results++;
      end
      if (n_results >= HOLD_AT && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      stall_cyc++;
      if (stall_cyc % 64 == 0)
        stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 3) == 0);
          2: stall_next = ($urandom_range(0, 9) < 7);
          default: stall_next = stall_cyc[0];
        endcase
      end
      rsp_stall <= stall_next;
    end
  end

  // Watchdog on cycles with no word moving on either side.
  int idle_cyc = 0;

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
      idle_cyc = 0;
    else
      idle_cyc++;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

### matrix_vector_transform_4x4.f
design/mvt_pkg.sv
design/mvt_lane.sv
design/mvt_merge.sv
design/matrix_vector_transform_4x4.sv
verif/testbench.sv
